FILE: src/lfgd_pkg.sv
// Shared types, codes and helpers of the linear fit gradient descent block.
package lfgd_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned WIDE_W = 64;
   localparam int unsigned LOSS_W = 31;
   localparam int unsigned EPS_W  = 17;
   localparam int unsigned ITER_W = 16;
   localparam int unsigned DIV_CNT_W = 6;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(WIDE_W - 1);
   localparam int unsigned CSR_ADDR_W = 4;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic signed [WIDE_W-1:0] MAX32 = WIDE_W'(64'sh7FFF_FFFF);
   localparam logic [LOSS_W-1:0] LOSS_MAX = '1;

   typedef enum logic [1:0] {
      REG_INIT_WEIGHT = 2'd0,
      REG_INIT_BIAS   = 2'd1,
      REG_STEP_SIZE   = 2'd2,
      REG_ITER_COUNT  = 2'd3
   } reg_index_type;

   typedef enum logic [3:0] {
      ST_LOAD,
      ST_START,
      ST_ITER,
      ST_READ,
      ST_MUL,
      ST_DIFF,
      ST_SQ,
      ST_ACC,
      ST_DIV,
      ST_STORE,
      ST_UPDATE,
      ST_DONE
   } state_type;

   typedef enum logic [1:0] {
      EVAL_BASE = 2'd0,
      EVAL_W    = 2'd1,
      EVAL_B    = 2'd2
   } eval_type;

   typedef struct packed {
      logic load;     // sample port open
      logic take;     // sample word accepted
      logic start;
      logic iter;
      logic rd;
      logic mul;
      logic diff;
      logic sq;
      logic acc;
      logic div;
      logic store;
      logic update;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic iter_zero;
      logic idx_last;
      logic div_last;
      logic eval_last;
      logic iter_last;
      logic out_free;
   } status_type;

   function automatic logic ovf32(input logic signed [WIDE_W-1:0] v);
      return v[WIDE_W-1:DATA_W-1] != {(WIDE_W-DATA_W+1){v[WIDE_W-1]}};
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      if (!ovf32(v)) return v[DATA_W-1:0];
      else if (v[WIDE_W-1]) return {1'b1, {(DATA_W-1){1'b0}}};
      else return {1'b0, {(DATA_W-1){1'b1}}};
   endfunction

endpackage

FILE: src/lfgd_csr.sv
// Configuration register file on an APB-style port.
module lfgd_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [lfgd_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [lfgd_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [lfgd_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready,
   output logic signed [lfgd_pkg::DATA_W-1:0]   init_weight,
   output logic signed [lfgd_pkg::DATA_W-1:0]   init_bias,
   output logic [lfgd_pkg::EPS_W-1:0]           step_size,
   output logic [lfgd_pkg::ITER_W-1:0]          iteration_count
);
   import lfgd_pkg::*;

   logic signed [DATA_W-1:0] weight_ff, bias_ff;
   logic [EPS_W-1:0]         eps_ff;
   logic [ITER_W-1:0]        iter_ff;
   reg_index_type            index;
   logic                     wr;

   assign csr_pready = 1'b1;
   assign index = reg_index_type'(csr_paddr[3:2]);
   assign wr = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         weight_ff <= '0;
         bias_ff   <= '0;
         eps_ff    <= EPS_W'(66);
         iter_ff   <= ITER_W'(600);
      end else if (wr) begin
         unique case (index)
            REG_INIT_WEIGHT: weight_ff <= csr_pwdata;
            REG_INIT_BIAS:   bias_ff   <= csr_pwdata;
            REG_STEP_SIZE:   eps_ff    <= csr_pwdata[EPS_W-1:0];
            REG_ITER_COUNT:  iter_ff   <= csr_pwdata[ITER_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_INIT_WEIGHT: csr_prdata = weight_ff;
         REG_INIT_BIAS:   csr_prdata = bias_ff;
         REG_STEP_SIZE:   csr_prdata = CSR_DATA_W'(eps_ff);
         REG_ITER_COUNT:  csr_prdata = CSR_DATA_W'(iter_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign init_weight     = weight_ff;
   assign init_bias       = bias_ff;
   assign step_size       = eps_ff;
   assign iteration_count = iter_ff;

endmodule

FILE: src/lfgd_ctrl.sv
// Sequencer for sample loading, loss evaluation and parameter updates.
module lfgd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tlast,
   input  lfgd_pkg::status_type   status,
   output lfgd_pkg::cmd_type      cmd
);
   import lfgd_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD:   if (req_tvalid && req_tlast) state_in = ST_START;
         ST_START:  state_in = status.iter_zero ? ST_DONE : ST_ITER;
         ST_ITER:   state_in = ST_READ;
         ST_READ:   state_in = ST_MUL;
         ST_MUL:    state_in = ST_DIFF;
         ST_DIFF:   state_in = ST_SQ;
         ST_SQ:     state_in = ST_ACC;
         ST_ACC:    state_in = status.idx_last ? ST_DIV : ST_READ;
         ST_DIV:    if (status.div_last) state_in = ST_STORE;
         ST_STORE:  state_in = status.eval_last ? ST_UPDATE : ST_READ;
         ST_UPDATE: state_in = status.iter_last ? ST_DONE : ST_ITER;
         ST_DONE:   if (status.out_free) state_in = ST_LOAD;
         default:   state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load = 1'b1;
            cmd.take = req_tvalid;
         end
         ST_START:  cmd.start  = 1'b1;
         ST_ITER:   cmd.iter   = 1'b1;
         ST_READ:   cmd.rd     = 1'b1;
         ST_MUL:    cmd.mul    = 1'b1;
         ST_DIFF:   cmd.diff   = 1'b1;
         ST_SQ:     cmd.sq     = 1'b1;
         ST_ACC:    cmd.acc    = 1'b1;
         ST_DIV:    cmd.div    = 1'b1;
         ST_STORE:  cmd.store  = 1'b1;
         ST_UPDATE: cmd.update = 1'b1;
         ST_DONE:   cmd.emit   = status.out_free;
         default: ;
      endcase
   end

endmodule

FILE: src/lfgd_dp.sv
// Sample store, loss arithmetic, divider and result register.
module lfgd_dp #(
   parameter int unsigned MAX_SAMPLES = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  lfgd_pkg::cmd_type                    cmd,
   output lfgd_pkg::status_type                 status,
   input  logic signed [lfgd_pkg::DATA_W-1:0]   init_weight,
   input  logic signed [lfgd_pkg::DATA_W-1:0]   init_bias,
   input  logic [lfgd_pkg::EPS_W-1:0]           step_size,
   input  logic [lfgd_pkg::ITER_W-1:0]          iteration_count,
   input  logic [63:0]                          req_tdata,
   input  logic                                 rsp_tready,
   output logic                                 rsp_tvalid,
   output logic [95:0]                          rsp_tdata,
   output logic                                 rsp_tuser
);
   import lfgd_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
   localparam int unsigned IDX_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;

   logic signed [DATA_W-1:0] mem_x [MAX_SAMPLES];
   logic signed [DATA_W-1:0] mem_y [MAX_SAMPLES];

   logic [CNT_W-1:0]         count_ff, n_ff;
   logic [IDX_W-1:0]         idx_ff;
   eval_type                 eval_ff;
   logic signed [DATA_W-1:0] w_ff, b_ff, we_ff, be_ff, x_rd_ff, y_rd_ff, d_ff;
   logic signed [WIDE_W-1:0] prod_ff, sq_ff, acc_ff;
   logic [WIDE_W-1:0]        q_ff;
   logic [CNT_W-1:0]         rem_ff;
   logic [DIV_CNT_W-1:0]     div_cnt_ff;
   logic [LOSS_W-1:0]        l0_ff, l1_ff, l2_ff, loss_ff;
   logic [ITER_W-1:0]        iter_ff;
   logic                     sat_ff, rsp_valid_ff, rsp_ovf_ff;
   logic [95:0]              rsp_data_ff;

   logic signed [DATA_W-1:0] wsel, bsel;
   logic signed [WIDE_W-1:0] we_sum, be_sum, diff_sum, prod_in, sq_in, acc_in;
   logic signed [WIDE_W-1:0] w_sum, b_sum;
   logic [CNT_W:0]           rem_sh;
   logic                     rem_ge;
   logic [LOSS_W-1:0]        mean;
   logic                     mean_ovf;

   assign wsel = (eval_ff == EVAL_W) ? we_ff : w_ff;
   assign bsel = (eval_ff == EVAL_B) ? be_ff : b_ff;

   assign we_sum   = WIDE_W'(w_ff) + WIDE_W'(step_size);
   assign be_sum   = WIDE_W'(b_ff) + WIDE_W'(step_size);
   assign prod_in  = wsel * x_rd_ff;
   assign diff_sum = (prod_ff >>> 16) + WIDE_W'(bsel) - WIDE_W'(y_rd_ff);
   assign sq_in    = d_ff * d_ff;
   assign acc_in   = acc_ff + (sq_ff >>> 16);
   assign w_sum    = WIDE_W'(w_ff) - (WIDE_W'(l1_ff) - WIDE_W'(l0_ff));
   assign b_sum    = WIDE_W'(b_ff) - (WIDE_W'(l2_ff) - WIDE_W'(l0_ff));

   assign rem_sh   = {rem_ff, q_ff[WIDE_W-1]};
   assign rem_ge   = rem_sh >= {1'b0, n_ff};
   assign mean_ovf = q_ff[WIDE_W-1:LOSS_W] != '0;
   assign mean     = mean_ovf ? LOSS_MAX : q_ff[LOSS_W-1:0];

   assign status.iter_zero = iteration_count == '0;
   assign status.idx_last  = (CNT_W'(idx_ff) + CNT_W'(1)) == n_ff;
   assign status.div_last  = div_cnt_ff == DIV_LAST;
   assign status.eval_last = eval_ff == EVAL_B;
   assign status.iter_last = (iter_ff + ITER_W'(1)) == iteration_count;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // sample memory
   always_ff @(posedge clock) begin
      if (cmd.take && count_ff < CNT_W'(MAX_SAMPLES)) begin
         mem_x[count_ff[IDX_W-1:0]] <= req_tdata[31:0];
         mem_y[count_ff[IDX_W-1:0]] <= req_tdata[63:32];
      end
      if (cmd.rd) begin
         x_rd_ff <= mem_x[idx_ff];
         y_rd_ff <= mem_y[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit) count_ff <= '0;
         else if (cmd.take && count_ff < CNT_W'(MAX_SAMPLES))
            count_ff <= count_ff + CNT_W'(1);
         if (cmd.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         n_ff    <= count_ff;
         w_ff    <= init_weight;
         b_ff    <= init_bias;
         iter_ff <= '0;
         loss_ff <= '0;
      end
      if (cmd.iter) begin
         we_ff   <= sat32(we_sum);
         be_ff   <= sat32(be_sum);
         eval_ff <= EVAL_BASE;
         idx_ff  <= '0;
         acc_ff  <= '0;
      end
      if (cmd.mul)  prod_ff <= prod_in;
      if (cmd.diff) d_ff    <= sat32(diff_sum);
      if (cmd.sq)   sq_ff   <= sq_in;
      if (cmd.acc) begin
         acc_ff <= acc_in;
         idx_ff <= idx_ff + IDX_W'(1);
         if (status.idx_last) begin
            q_ff       <= acc_in;
            rem_ff     <= '0;
            div_cnt_ff <= '0;
         end
      end
      if (cmd.div) begin
         // restoring division, one quotient bit per cycle
         q_ff       <= {q_ff[WIDE_W-2:0], rem_ge};
         rem_ff     <= rem_ge ? CNT_W'(rem_sh - {1'b0, n_ff}) : rem_sh[CNT_W-1:0];
         div_cnt_ff <= div_cnt_ff + DIV_CNT_W'(1);
      end
      if (cmd.store) begin
         case (eval_ff)
            EVAL_BASE: l0_ff <= mean;
            EVAL_W:    l1_ff <= mean;
            default:   l2_ff <= mean;
         endcase
         eval_ff <= eval_type'(eval_ff + 2'd1);
         idx_ff  <= '0;
         acc_ff  <= '0;
      end
      if (cmd.update) begin
         w_ff    <= sat32(w_sum);
         b_ff    <= sat32(b_sum);
         loss_ff <= l0_ff;
         iter_ff <= iter_ff + ITER_W'(1);
      end
      if (cmd.emit) begin
         rsp_data_ff <= {1'b0, loss_ff, b_ff, w_ff};
         rsp_ovf_ff  <= sat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start) sat_ff <= 1'b0;
      else if ((cmd.iter && (ovf32(we_sum) || ovf32(be_sum)))
               || (cmd.diff && ovf32(diff_sum))
               || (cmd.store && mean_ovf)
               || (cmd.update && (ovf32(w_sum) || ovf32(b_sum))))
         sat_ff <= 1'b1;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

FILE: src/linear_fit_gradient_descent.sv
// Top level of the linear fit gradient descent block.
//
// Sample words arrive on the req_ stream, one (x, y) pair in Q16.16 per word.
// They are stored, up to MAX_SAMPLES of them; further words are dropped.
// The word with req_tlast set ends the set and starts a fit y = w*x + b,
// beginning from init_weight / init_bias, for iteration_count iterations.
// Loading takes one word per cycle; the port is closed during a fit.
// One iteration evaluates three losses. Each loss walks the n stored samples
// through read, multiply, difference, square and accumulate steps, then a
// bit-serial divider by n and one store step.
// The result word on rsp_ carries weight, bias, last loss and an overflow
// flag. It sits in an output register; while the receiver stalls, new
// samples are still taken, but the next fit waits to post until the
// register is free.
// Reset (synchronous) empties the sample count, drops any pending result
// and restores the register defaults (step 66, 600 iterations).
module linear_fit_gradient_descent #(
   parameter int unsigned MAX_SAMPLES = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // sample_x, sample_y
   input  logic         req_tlast,   // last_sample
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // fitted_weight, fitted_bias, mean_sq_error, pad
   output logic         rsp_tuser,   // overflowed
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import lfgd_pkg::*;

   cmd_type                  cmd;
   status_type               status;
   logic signed [DATA_W-1:0] init_weight, init_bias;
   logic [EPS_W-1:0]         step_size;
   logic [ITER_W-1:0]        iteration_count;

   lfgd_csr u_csr (
      .clock, .reset,
      .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr, .csr_pwdata,
      .csr_prdata, .csr_pready,
      .init_weight, .init_bias, .step_size, .iteration_count
   );

   lfgd_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tlast, .status, .cmd
   );

   lfgd_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
      .clock, .reset, .cmd, .status,
      .init_weight, .init_bias, .step_size, .iteration_count,
      .req_tdata, .rsp_tready, .rsp_tvalid, .rsp_tdata, .rsp_tuser
   );

   assign req_tready = cmd.load;

endmodule

FILE: src/lfgd_checker.sv
// Port-level checks of the linear fit block and their binding.
module lfgd_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         req_tlast,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [95:0]  rsp_tdata
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_fit_closes: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("sample port open after last word");

   a_post_after_fit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result posted while loading");

endmodule

bind linear_fit_gradient_descent lfgd_checker u_lfgd_checker (
   .clock, .reset, .req_tvalid, .req_tready, .req_tlast,
   .rsp_tvalid, .rsp_tready, .rsp_tdata
);
